// ----- hw/rtl/bss_pkg.sv -----
// ----------------------------------------------------------------------------
// bss_pkg
// Shared types and constants for the bounded stack with search.
// ----------------------------------------------------------------------------
package bss_pkg;

  localparam int unsigned DEPTH_DEF   = 16;
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned REQ_W       = 2;
  localparam int unsigned STAT_W      = 2;
  localparam int unsigned POS_W       = 4;
  localparam int unsigned CNT_OUT_W   = 5;
  localparam int unsigned RES_W       = 1 + STAT_W + POS_W + CNT_OUT_W;
  localparam int unsigned OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH   = 2'd0,
    REQ_POP    = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_SEARCH = 2'd3
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_FOUND = 2'd0,
    STAT_MISS  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  // memory port strobes from the controller
  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

endpackage

// ----- hw/rtl/bss_mem.sv -----
// ----------------------------------------------------------------------------
// bss_mem
// Stack storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bss_mem import bss_pkg::*; #(
  parameter int unsigned DEPTH  = DEPTH_DEF,
  parameter int unsigned ADDR_W = 4
) (
  input  logic               clk_i,
  input  mem_ctl_t           ctl_i,
  input  logic [ADDR_W-1:0]  waddr_i,
  input  logic [VALUE_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0]  raddr_i,
  output logic [VALUE_W-1:0] rdata_o
);

  logic [VALUE_W-1:0] mem_q [DEPTH];
  logic [VALUE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.re) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/bss_ctrl.sv -----
// ----------------------------------------------------------------------------
// bss_ctrl
// Request sequencer: fill count, search scan over the memory, result register.
// ----------------------------------------------------------------------------
module bss_ctrl import bss_pkg::*; #(
  parameter int unsigned DEPTH  = DEPTH_DEF,
  parameter int unsigned ADDR_W = 4,
  parameter int unsigned CNT_W  = 5
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [VALUE_W-1:0]     s_axis_tdata,
  input  logic [REQ_W-1:0]       s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output mem_ctl_t               mem_ctl_o,
  output logic [ADDR_W-1:0]      mem_waddr_o,
  output logic [VALUE_W-1:0]     mem_wdata_o,
  output logic [ADDR_W-1:0]      mem_raddr_o,
  input  logic [VALUE_W-1:0]     mem_rdata_i
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SRCH = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [VALUE_W-1:0] key_q, key_d;
  logic [CNT_W-1:0]   rd_idx_q, rd_idx_d;
  logic               cmp_vld_q, cmp_vld_d;
  logic [ADDR_W-1:0]  cmp_idx_q, cmp_idx_d;
  status_e            res_stat_q, res_stat_d;
  logic [ADDR_W-1:0]  res_pos_q, res_pos_d;

  logic               out_vld_q, out_vld_d;
  logic               out_acc_q;
  status_e            out_stat_q;
  logic [ADDR_W-1:0]  out_pos_q;
  logic [CNT_W-1:0]   out_cnt_q;

  logic               load;
  logic               ld_acc;
  status_e            ld_stat;
  logic [ADDR_W-1:0]  ld_pos;
  logic [CNT_W-1:0]   ld_cnt;

  logic               out_free;
  logic               accept;
  logic               full;
  logic               last_cmp;
  logic               hit;

  logic [ADDR_W+POS_W-1:0]   pos_ext;
  logic [CNT_W+CNT_OUT_W-1:0] cnt_ext;

  assign out_free      = !out_vld_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign full          = (cnt_q == CNT_W'(DEPTH));
  assign last_cmp      = ((CNT_W'(cmp_idx_q) + CNT_W'(1)) == cnt_q);
  assign hit           = cmp_vld_q && (mem_rdata_i == key_q);

  // push writes at the top while idle; the scan only reads in S_SRCH, so
  // no read can meet a write to the same entry
  assign mem_waddr_o = cnt_q[ADDR_W-1:0];
  assign mem_wdata_o = s_axis_tdata;
  assign mem_raddr_o = rd_idx_q[ADDR_W-1:0];

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    key_d        = key_q;
    rd_idx_d     = rd_idx_q;
    cmp_vld_d    = cmp_vld_q;
    cmp_idx_d    = cmp_idx_q;
    res_stat_d   = res_stat_q;
    res_pos_d    = res_pos_q;
    mem_ctl_o.we = 1'b0;
    mem_ctl_o.re = 1'b0;
    load         = 1'b0;
    ld_acc       = 1'b0;
    ld_stat      = STAT_MISS;
    ld_pos       = '0;
    ld_cnt       = cnt_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          load = 1'b1;
          case (req_e'(s_axis_tuser))
            REQ_PUSH: begin
              if (!full) begin
                mem_ctl_o.we = 1'b1;
                cnt_d        = cnt_q + CNT_W'(1);
                ld_acc       = 1'b1;
              end
            end
            REQ_POP: begin
              if (cnt_q != '0) begin
                cnt_d  = cnt_q - CNT_W'(1);
                ld_acc = 1'b1;
              end
            end
            REQ_CLEAR: begin
              cnt_d  = '0;
              ld_acc = 1'b1;
            end
            default: begin
              if (cnt_q == '0) begin
                ld_stat = STAT_EMPTY;
              end else begin
                load      = 1'b0;
                key_d     = s_axis_tdata;
                rd_idx_d  = '0;
                cmp_vld_d = 1'b0;
                state_d   = S_SRCH;
              end
            end
          endcase
          ld_cnt = cnt_d;
        end
      end
      S_SRCH: begin
        // one read issued and one entry compared per cycle
        if (hit) begin
          res_stat_d = STAT_FOUND;
          res_pos_d  = cmp_idx_q;
          cmp_vld_d  = 1'b0;
          state_d    = S_RESP;
        end else if (cmp_vld_q && last_cmp) begin
          res_stat_d = STAT_MISS;
          res_pos_d  = '0;
          cmp_vld_d  = 1'b0;
          state_d    = S_RESP;
        end else if (rd_idx_q < cnt_q) begin
          mem_ctl_o.re = 1'b1;
          cmp_vld_d    = 1'b1;
          cmp_idx_d    = rd_idx_q[ADDR_W-1:0];
          rd_idx_d     = rd_idx_q + CNT_W'(1);
        end
      end
      S_RESP: begin
        if (out_free) begin
          load    = 1'b1;
          ld_stat = res_stat_q;
          ld_pos  = res_pos_q;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    out_vld_d = (out_vld_q && !m_axis_tready) || load;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      rd_idx_q  <= '0;
      cmp_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      rd_idx_q  <= rd_idx_d;
      cmp_vld_q <= cmp_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    cmp_idx_q  <= cmp_idx_d;
    res_stat_q <= res_stat_d;
    res_pos_q  <= res_pos_d;
    if (load) begin
      out_acc_q  <= ld_acc;
      out_stat_q <= ld_stat;
      out_pos_q  <= ld_pos;
      out_cnt_q  <= ld_cnt;
    end
  end

  assign pos_ext = {{POS_W{1'b0}}, out_pos_q};
  assign cnt_ext = {{CNT_OUT_W{1'b0}}, out_cnt_q};

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W - RES_W){1'b0}},
                          cnt_ext[CNT_OUT_W-1:0],
                          pos_ext[POS_W-1:0],
                          out_stat_q,
                          out_acc_q};

endmodule

// ----- hw/rtl/bounded_stack_with_search.sv -----
// ----------------------------------------------------------------------------
// bounded_stack_with_search
// LIFO stack of signed 32-bit values with push, pop, clear and linear search.
// ----------------------------------------------------------------------------
// Push, pop and clear can be accepted back to back as long as results are
// taken. A search on a non-empty stack scans the memory from the bottom entry,
// one entry per cycle through its single read port, and stops at the first
// match or after comparing the top entry; no request is taken while it runs.
// A search of an empty stack does not scan and answers with the empty status.
// The result beat waits in an output register; a new request is taken only
// while that register is empty or its beat is taken in the same cycle, so a
// stalled result holds off input.
module bounded_stack_with_search import bss_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [VALUE_W-1:0]     s_axis_tdata,  // value
  input  logic [REQ_W-1:0]       s_axis_tuser,  // req_type
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // accepted, search_status, found_position, entry_count, zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  mem_ctl_t           mem_ctl;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [VALUE_W-1:0] mem_wdata;
  logic [ADDR_W-1:0]  mem_raddr;
  logic [VALUE_W-1:0] mem_rdata;

  bss_ctrl #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W),
    .CNT_W  (CNT_W)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .mem_ctl_o     (mem_ctl),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_raddr_o   (mem_raddr),
    .mem_rdata_i   (mem_rdata)
  );

  bss_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

// ----- hw/rtl/bss_chk.sv -----
// ----------------------------------------------------------------------------
// bss_chk
// Port-level checks for the bounded stack with search, bound to the top.
// ----------------------------------------------------------------------------
module bss_chk import bss_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic [VALUE_W-1:0]     s_axis_tdata,
  input logic [REQ_W-1:0]       s_axis_tuser,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic                 acc;
  logic [STAT_W-1:0]    stat;
  logic [POS_W-1:0]     pos;
  logic [CNT_OUT_W-1:0] cnt;

  assign acc  = m_axis_tdata[0];
  assign stat = m_axis_tdata[STAT_W:1];
  assign pos  = m_axis_tdata[STAT_W+POS_W:STAT_W+1];
  assign cnt  = m_axis_tdata[RES_W-1:STAT_W+POS_W+1];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  a_acc_no_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && acc |-> stat == STAT_MISS)
    else $error("accepted beat carries search status");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && stat == STAT_EMPTY |-> cnt == '0 && pos == '0 && !acc)
    else $error("empty status with nonzero fields");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && !s_axis_tready |=>
      s_axis_tvalid && $stable({s_axis_tuser, s_axis_tdata}))
    else $error("request beat changed while waiting");

  a_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && stat != STAT_FOUND |-> pos == '0)
    else $error("position set without a match");

endmodule

bind bounded_stack_with_search bss_chk u_bss_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
